@@ design/animation_frame_stepper_assert.svh @@
// Assertion macros used by the animation frame stepper checker.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef ANIMATION_FRAME_STEPPER_ASSERT_SVH
`define ANIMATION_FRAME_STEPPER_ASSERT_SVH

// Checked only while reset is released.
`define AFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define AFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/afs_pkg.sv @@
// Shared types and constants for the animation frame stepper.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package afs_pkg;

  localparam int unsigned TargetW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_TOTAL = 2'd0,
    REG_CLAMP_MODE  = 2'd1,
    REG_STEP_RATE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic load_item;
    logic step;
    logic commit;
  } afs_cmd_t;

  typedef struct packed {
    logic need_div;
  } afs_status_t;

endpackage

`default_nettype wire

@@ design/afs_ctrl.sv @@
// Controller state machine of the animation frame stepper.
// Depends on afs_pkg; drives the datapath commands and the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module afs_ctrl
  import afs_pkg::*;
#(
  parameter int unsigned ITERS = 30
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire afs_status_t status_i,
  output afs_cmd_t         cmd_o
);

  localparam int unsigned CntW = $clog2(ITERS);
  localparam logic [CntW-1:0] LastCnt = CntW'(ITERS - 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cnt_d           = '0;
          state_d         = StRun;
        end
      end
      StRun: begin
        if (!status_i.need_div) begin
          state_d = StFin;
        end else begin
          cmd_o.step = 1'b1;
          if (cnt_q == LastCnt) begin
            state_d = StFin;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/afs_dp.sv @@
// Datapath of the animation frame stepper: registers, serial remainder, pass test.
// Depends on afs_pkg; sequenced by afs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module afs_dp
  import afs_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 12,
  parameter int unsigned FRAME_BITS    = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]                       cfg_idx_i,
  input  wire logic [FRAME_BITS+FRACTION_BITS:0]        cfg_wdata_i,
  input  wire logic                                     func_i,
  input  wire logic signed [TargetW-1:0]                target_frame_i,
  input  wire logic [FRAME_BITS-1:0]                    start_frame_i,
  input  wire afs_cmd_t                                 cmd_i,
  output afs_status_t                                   status_o,
  output logic                                          passed_target_o,
  output logic                                          done_flag_o,
  output logic signed [FRAME_BITS+FRACTION_BITS:0]      position_out_o,
  output logic signed [FRAME_BITS:0]                    whole_frame_o
);

  localparam int unsigned PosW  = FRAME_BITS + FRACTION_BITS + 1;
  localparam int unsigned SpanW = FRAME_BITS + FRACTION_BITS;
  localparam int unsigned SumW  = PosW + 2;
  localparam int unsigned MagW  = SumW - 1;
  localparam int unsigned TgtW  = TargetW + FRACTION_BITS;
  localparam int unsigned CmpW  = ((SumW > TgtW) ? SumW : TgtW) + 1;

  logic [FRAME_BITS-1:0]   frame_total_q;
  logic                    clamp_q;
  logic signed [PosW-1:0]  rate_q;
  logic signed [PosW-1:0]  pos_q;

  logic                    func_q;
  logic signed [CmpW-1:0]  tgt_q;
  logic [FRAME_BITS-1:0]   start_q;
  logic signed [SumW-1:0]  nxt_q;
  logic                    neg_q;
  logic [MagW-1:0]         mag_q;
  logic [SpanW-1:0]        rem_q;

  logic                    passed_q, done_q;
  logic signed [PosW-1:0]  pos_out_q;

  logic [FRAME_BITS-1:0]   frames;
  logic [SpanW-1:0]        span;
  logic signed [SumW-1:0]  nxt_w, sum_w;
  logic [SumW-1:0]         abs_w;
  logic [SpanW:0]          rem_sh;
  logic [SpanW-1:0]        rem_d;
  logic signed [CmpW-1:0]  span_c, pos_c, nxt_c, rem_c, clamp_c, new_c;
  logic signed [PosW-1:0]  rem_pos, rem_s, clamp_v, loaded_v, new_pos;
  logic                    passed_w, done_w;

  function automatic logic in_swept(input logic signed [CmpW-1:0] cur,
                                    input logic signed [CmpW-1:0] nxt,
                                    input logic signed [CmpW-1:0] tgt);
    logic res;
    if (cur <= nxt) begin
      res = (cur <= tgt) && (tgt < nxt);
    end else begin
      res = (nxt <= tgt) && (tgt < cur);
    end
    return res;
  endfunction

  assign frames = (frame_total_q == '0) ? FRAME_BITS'(1) : frame_total_q;
  assign span   = {frames, {FRACTION_BITS{1'b0}}};

  // Dividend of the loop-mode remainder: position + rate + span.
  assign nxt_w = SumW'(pos_q) + SumW'(rate_q);
  assign sum_w = nxt_w + $signed(SumW'(span));
  assign abs_w = sum_w[SumW-1] ? SumW'(-sum_w) : SumW'(sum_w);

  // One restoring step of the remainder by span per cycle.
  assign rem_sh = {rem_q, mag_q[MagW-1]};
  assign rem_d  = (rem_sh >= {1'b0, span}) ? SpanW'(rem_sh - {1'b0, span})
                                           : SpanW'(rem_sh);

  assign rem_pos  = PosW'(rem_q);
  assign rem_s    = neg_q ? -rem_pos : rem_pos;
  assign span_c   = $signed(CmpW'(span));
  assign pos_c    = CmpW'(pos_q);
  assign nxt_c    = CmpW'(nxt_q);
  assign rem_c    = CmpW'(rem_s);
  assign clamp_v  = (nxt_c < 0) ? PosW'(0)
                  : (nxt_c >= span_c) ? $signed(PosW'(span - 1'b1)) : PosW'(nxt_q);
  assign clamp_c  = CmpW'(clamp_v);
  assign loaded_v = $signed(PosW'({start_q, {FRACTION_BITS{1'b0}}}));
  assign new_pos  = func_q ? loaded_v : (clamp_q ? clamp_v : rem_s);
  assign new_c    = CmpW'(new_pos);

  always_comb begin
    if (func_q) begin
      passed_w = 1'b0;
    end else if (clamp_q) begin
      passed_w = in_swept(pos_c, clamp_c, tgt_q);
    end else if (nxt_c < 0) begin
      passed_w = ((tgt_q >= 0) && (tgt_q < pos_c)) || ((rem_c <= tgt_q) && (tgt_q < span_c));
    end else if (nxt_c >= span_c) begin
      passed_w = ((pos_c <= tgt_q) && (tgt_q < span_c)) || (tgt_q < rem_c);
    end else begin
      passed_w = in_swept(pos_c, nxt_c, tgt_q);
    end
  end

  assign done_w = (rate_q < 0) ? (new_c <= 0) : (new_c >= span_c - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_total_q <= FRAME_BITS'(1);
      clamp_q       <= 1'b0;
      rate_q        <= PosW'(1) << FRACTION_BITS;
      pos_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FRAME_TOTAL: frame_total_q <= cfg_wdata_i[FRAME_BITS-1:0];
          REG_CLAMP_MODE:  clamp_q       <= cfg_wdata_i[0];
          REG_STEP_RATE:   rate_q        <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        pos_q <= new_pos;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q  <= func_i;
      tgt_q   <= CmpW'(target_frame_i) <<< FRACTION_BITS;
      start_q <= start_frame_i;
      nxt_q   <= nxt_w;
      neg_q   <= sum_w[SumW-1];
      mag_q   <= abs_w[MagW-1:0];
      rem_q   <= '0;
    end else if (cmd_i.step) begin
      mag_q <= mag_q << 1;
      rem_q <= rem_d;
    end
    if (cmd_i.commit) begin
      passed_q  <= passed_w;
      done_q    <= done_w;
      pos_out_q <= new_pos;
    end
  end

  assign status_o.need_div = !func_q && !clamp_q;

  assign passed_target_o = passed_q;
  assign done_flag_o     = done_q;
  assign position_out_o  = pos_out_q;
  assign whole_frame_o   = pos_out_q[PosW-1:FRACTION_BITS];

endmodule

`default_nettype wire

@@ design/animation_frame_stepper.sv @@
// Top level of the animation frame stepper.
// Instantiates afs_ctrl and afs_dp; types and constants come from afs_pkg.
//
// Usage: configure frame_total, clamp_mode and step_rate through the write
// port while the block is idle. Each input beat is either a tick (func 0),
// which tests target_frame for being passed and advances the position, or a
// load (func 1), which sets the position to start_frame. Every input beat
// yields exactly one output beat with passed_target, done_flag, position_out
// and whole_frame. In loop mode a tick runs a serial remainder by the span,
// one dividend bit per cycle over FRAME_BITS + FRACTION_BITS + 2 bits, before
// the result is committed; loads and clamp-mode ticks skip the remainder.
// The input is stalled while an item is in work. A finished result waits in
// the datapath while the output register is full and stalled; the output
// register itself holds its beat until taken, and new input is accepted
// meanwhile. Reset clears the position to zero and restores frame_total 1,
// loop mode and a rate of one frame per tick.
`timescale 1ns / 1ps
`default_nettype none

module animation_frame_stepper
  import afs_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 12,
  parameter int unsigned FRAME_BITS    = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]                   cfg_idx_i,
  input  wire logic [FRAME_BITS+FRACTION_BITS:0]    cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 func_i,
  input  wire logic signed [TargetW-1:0]            target_frame_i,
  input  wire logic [FRAME_BITS-1:0]                start_frame_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      passed_target_o,
  output logic                                      done_flag_o,
  output logic signed [FRAME_BITS+FRACTION_BITS:0]  position_out_o,
  output logic signed [FRAME_BITS:0]                whole_frame_o
);

  localparam int unsigned Iters = FRAME_BITS + FRACTION_BITS + 2;

  afs_cmd_t    cmd;
  afs_status_t status;

  afs_ctrl #(
    .ITERS(Iters)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  afs_dp #(
    .FRACTION_BITS(FRACTION_BITS),
    .FRAME_BITS   (FRAME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .target_frame_i (target_frame_i),
    .start_frame_i  (start_frame_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .passed_target_o(passed_target_o),
    .done_flag_o    (done_flag_o),
    .position_out_o (position_out_o),
    .whole_frame_o  (whole_frame_o)
  );

endmodule

`default_nettype wire

@@ design/afs_checker.sv @@
// Port-level assertions for the animation frame stepper, bound to the top level.
// Depends on afs_pkg and the macros in animation_frame_stepper_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "animation_frame_stepper_assert.svh"

module afs_checker
  import afs_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 12,
  parameter int unsigned FRAME_BITS    = 16
) (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_stall_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic signed [FRAME_BITS+FRACTION_BITS:0] position_out_o,
  input wire logic signed [FRAME_BITS:0]           whole_frame_o
);

  localparam int unsigned PosW = FRAME_BITS + FRACTION_BITS + 1;

  `AFS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "output beat dropped while stalled")
  `AFS_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(position_out_o), "stalled position changed")
  `AFS_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "input not stalled while an item is in work")
  `AFS_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared without an item in work")
  `AFS_ASSERT(a_whole_frame, clk_i, rst_ni, out_valid_o |-> whole_frame_o == position_out_o[PosW-1:FRACTION_BITS], "whole frame does not match position")

endmodule

bind animation_frame_stepper afs_checker #(
  .FRACTION_BITS(FRACTION_BITS),
  .FRAME_BITS   (FRAME_BITS)
) u_afs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .position_out_o(position_out_o),
  .whole_frame_o (whole_frame_o)
);

`default_nettype wire

@@ verif/tb_animation_frame_stepper.sv @@
// Self-checking testbench for animation_frame_stepper: directed and random ticks and loads
// under several register settings and handshake pressure, checked against a local predictor.
// Depends on afs_pkg and the animation_frame_stepper RTL only.
`timescale 1ns / 1ps

module tb_animation_frame_stepper;
  import afs_pkg::*;

  localparam int FracBits    = 12;
  localparam int PosW        = 29;
  localparam int WholeW      = 17;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 40;

  localparam logic FuncTick = 1'b0;
  localparam logic FuncLoad = 1'b1;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic                  func;
    logic signed [TargetW-1:0] target;
    logic [15:0]           start;
  } frame_cmd_t;

  typedef struct packed {
    logic                    passed;
    logic                    done;
    logic signed [PosW-1:0]  pos;
    logic signed [WholeW-1:0] whole;
  } frame_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i = '0;
  logic [PosW-1:0]           cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      func_i = 1'b0;
  logic signed [TargetW-1:0] target_frame_i = '0;
  logic [15:0]               start_frame_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      passed_target_o;
  logic                      done_flag_o;
  logic signed [PosW-1:0]    position_out_o;
  logic signed [WholeW-1:0]  whole_frame_o;

  frame_cmd_t    cmd_queue[$];
  frame_result_t expected_frames[$];
  frame_cmd_t    next_cmd;
  frame_result_t want;

  logic [15:0] cfg_frames = 16'd1;
  logic        cfg_clamp = 1'b0;
  longint      cfg_rate = 4096;
  longint      track_pos = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  animation_frame_stepper u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .target_frame_i (target_frame_i),
    .start_frame_i  (start_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .passed_target_o(passed_target_o),
    .done_flag_o    (done_flag_o),
    .position_out_o (position_out_o),
    .whole_frame_o  (whole_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic in_swept(input longint cur, input longint nxt, input longint tgt);
    if (cur <= nxt) return (cur <= tgt) && (tgt < nxt);
    return (nxt <= tgt) && (tgt < cur);
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] data);
    case (idx)
      REG_FRAME_TOTAL: cfg_frames = data[15:0];
      REG_CLAMP_MODE:  cfg_clamp = data[0];
      REG_STEP_RATE:   cfg_rate = longint'($signed(data));
      default: ;
    endcase
  endfunction

  function automatic frame_result_t step_animation(input logic func,
                                                   input logic signed [TargetW-1:0] tgt_frame,
                                                   input logic [15:0] start);
    frame_result_t r;
    longint span, nxt, tgt, pos_after, whole;
    logic passed;
    span = ((cfg_frames == 16'd0) ? longint'(1) : longint'(cfg_frames)) << FracBits;
    passed = 1'b0;
    if (func == FuncLoad) begin
      pos_after = longint'(start) << FracBits;
    end else begin
      tgt = longint'(tgt_frame) * (longint'(1) << FracBits);
      nxt = track_pos + cfg_rate;
      if (!cfg_clamp) begin
        if (nxt < 0) begin
          nxt = (nxt + span) % span;
          passed = ((tgt >= 0) && (tgt < track_pos)) || ((nxt <= tgt) && (tgt < span));
        end else if (nxt >= span) begin
          nxt = nxt % span;
          passed = ((track_pos <= tgt) && (tgt < span)) || (tgt < nxt);
        end else begin
          passed = in_swept(track_pos, nxt, tgt);
        end
        pos_after = (track_pos + cfg_rate + span) % span;
      end else begin
        if (nxt < 0) nxt = 0;
        if (nxt >= span) nxt = span - 1;
        passed = in_swept(track_pos, nxt, tgt);
        pos_after = nxt;
      end
    end
    track_pos = pos_after;
    whole = pos_after >>> FracBits;
    r.passed = passed;
    r.done = (cfg_rate < 0) ? (pos_after <= 0) : (pos_after >= span - 1);
    r.pos = pos_after[PosW-1:0];
    r.whole = whole[WholeW-1:0];
    return r;
  endfunction

  task automatic report_field(input string field, input longint exp_val, input longint act_val);
    $display("%0t %s mismatch: expected %0d actual %0d", $time, field, exp_val, act_val);
    mismatches++;
  endtask

  // Input side: a beat is taken when valid is high and stall low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_frames.push_back(step_animation(func_i, target_frame_i, start_frame_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_cmd = cmd_queue.pop_front();
          in_valid_i <= 1'b1;
          func_i <= next_cmd.func;
          target_frame_i <= next_cmd.target;
          start_frame_i <= next_cmd.start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          $display("%0t unexpected beat: expected none actual position_out %0d", $time,
                   position_out_o);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (passed_target_o !== want.passed)
            report_field("passed_target", want.passed, passed_target_o);
          if (done_flag_o !== want.done)
            report_field("done_flag", want.done, done_flag_o);
          if (position_out_o !== want.pos)
            report_field("position_out", $signed(want.pos), position_out_o);
          if (whole_frame_o !== want.whole)
            report_field("whole_frame", $signed(want.whole), whole_frame_o);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("tb_animation_frame_stepper: errors");
    $finish;
  end

  task automatic queue_cmd(input logic func, input int tgt, input int start);
    frame_cmd_t c;
    c.func = func;
    c.target = TargetW'(tgt);
    c.start = 16'(start);
    cmd_queue.push_back(c);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || in_valid_i || expected_frames.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    apply_reg(idx, data);
  endtask

  // Unused high bits carry noise; the spare index must be ignored.
  task automatic program_regs(input logic [15:0] frames, input logic clamp, input longint rate);
    write_reg(RegSpare, PosW'($urandom));
    write_reg(REG_FRAME_TOTAL, {13'($urandom), frames});
    write_reg(REG_CLAMP_MODE, {28'($urandom), clamp});
    write_reg(REG_STEP_RATE, PosW'(rate));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  initial begin : stimulus
    logic [15:0] frames;
    longint span, rate, eff;
    int sel;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_idle(0);
    queue_cmd(FuncTick, 0, 0);
    queue_cmd(FuncTick, -32768, 0);
    queue_cmd(FuncTick, 32767, 16'hFFFF);
    queue_cmd(FuncLoad, 0, 16'hFFFF);
    queue_cmd(FuncTick, -1, 0);
    queue_cmd(FuncLoad, -1, 0);
    wait_idle();

    program_regs(16'd0, 1'b0, -(longint'(1) << 28));
    queue_cmd(FuncLoad, 0, 1);
    queue_cmd(FuncTick, 0, 0);
    queue_cmd(FuncTick, -1, 0);
    queue_cmd(FuncTick, 1, 0);
    queue_cmd(FuncTick, 0, 0);
    wait_idle();

    program_regs(16'hFFFF, 1'b1, (longint'(1) << 28) - 1);
    queue_cmd(FuncLoad, 0, 0);
    queue_cmd(FuncTick, 32767, 0);
    queue_cmd(FuncTick, -32768, 0);
    queue_cmd(FuncLoad, 0, 16'hFFFF);
    queue_cmd(FuncTick, 100, 0);
    wait_idle();

    program_regs(16'd10, 1'b0, -3 * 4096 - 100);
    queue_cmd(FuncLoad, 0, 2);
    queue_cmd(FuncTick, 9, 0);
    queue_cmd(FuncTick, 0, 0);
    wait_idle();

    program_regs(16'd10, 1'b0, 5 * 4096 + 7);
    queue_cmd(FuncLoad, 0, 8);
    queue_cmd(FuncTick, -5, 0);
    queue_cmd(FuncTick, 3, 0);
    wait_idle();

    program_regs(16'd4, 1'b1, -2 * 4096);
    queue_cmd(FuncLoad, 0, 3);
    queue_cmd(FuncTick, 1, 0);
    queue_cmd(FuncTick, 0, 0);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      set_idle(phase % 4);
      sel = $urandom_range(0, 9);
      if (sel == 0) frames = 16'd0;
      else if (sel == 1) frames = 16'hFFFF;
      else if (sel == 2) frames = 16'd1;
      else if (sel == 3) frames = 16'($urandom);
      else frames = 16'($urandom_range(2, 24));
      eff = (frames == 16'd0) ? 1 : longint'(frames);
      span = eff << FracBits;
      sel = $urandom_range(0, 9);
      if (sel == 0) rate = -(longint'(1) << 28);
      else if (sel == 1) rate = (longint'(1) << 28) - 1;
      else if (sel == 2) rate = 0;
      else rate = longint'($urandom_range(0, 32'(3 * span))) - (3 * span) / 2;
      if (rate < -(longint'(1) << 28)) rate = -(longint'(1) << 28);
      if (rate > (longint'(1) << 28) - 1) rate = (longint'(1) << 28) - 1;
      program_regs(frames, 1'($urandom), rate);
      for (int n = 0; n < 56; n++) begin
        sel = $urandom_range(0, 7);
        queue_cmd(($urandom_range(0, 99) < 12) ? FuncLoad : FuncTick,
                  (sel == 0) ? int'($urandom) :
                  (sel == 1) ? -int'($urandom_range(1, 4)) :
                  int'($urandom_range(0, 32'(eff + 1))),
                  (sel == 2) ? int'($urandom) : int'($urandom_range(0, 32'(eff))));
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("tb_animation_frame_stepper: clean");
    end else begin
      $display("tb_animation_frame_stepper: errors");
    end
    $finish;
  end

endmodule
